/* hw/rtl/mpe_pkg.sv */
package mpe_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_INDEX_BITS = 2;
  localparam int SHIFT_BITS     = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS_X = 2'd2,
    CFG_RADIUS_Y = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef struct packed {
    acc_op_t               op;
    logic [SHIFT_BITS-1:0] shift;
  } mac_ctl_t;

endpackage

/* hw/rtl/mpe_mac.sv */
module mpe_mac #(
  parameter int A_BITS   = 2 * (mpe_pkg::COORD_BITS_DEF - 1),
  parameter int B_BITS   = 2 * mpe_pkg::COORD_BITS_DEF,
  parameter int ACC_BITS = 4 * mpe_pkg::COORD_BITS_DEF + 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mpe_pkg::mac_ctl_t          ctl,
  input  logic [A_BITS-1:0]          op_a,
  input  logic [B_BITS-1:0]          op_b,
  output logic [A_BITS+B_BITS-1:0]   prod,
  output logic                       acc_neg,
  output logic                       acc_zero
);

  localparam int P_BITS = A_BITS + B_BITS;

  logic [ACC_BITS-1:0] acc;
  logic [ACC_BITS-1:0] acc_next;
  logic [ACC_BITS-1:0] term;

  // product is registered; the accumulator consumes it in the following cycle
  always_ff @(posedge clk) begin
    prod <= P_BITS'(op_a) * P_BITS'(op_b);
  end

  assign term = ACC_BITS'(prod) << ctl.shift;

  always_comb begin
    case (ctl.op)
      mpe_pkg::ACC_LOAD: acc_next = term;
      mpe_pkg::ACC_ADD:  acc_next = acc + term;
      mpe_pkg::ACC_SUB:  acc_next = acc - term;
      default:           acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  assign acc_neg  = acc[ACC_BITS-1];
  assign acc_zero = (acc == '0);

endmodule

/* hw/rtl/midpoint_ellipse_point_generator.sv */
// Midpoint ellipse point generator.
// Config port: write center_x, center_y, radius_x, radius_y with cfg_we/cfg_index/cfg_data
// while no beat is in flight. A radius write holds req_stall high
// while the squared radii are rebuilt.
// Request channel (req_valid/req_stall, field restart): restart=1 starts a new ellipse at
// the top point, restart=0 advances to the next point. Every request beat yields exactly
// one result beat on res_valid/res_stall: the four mirrored coordinates, point_valid, and
// final_point on the y=0 row. After the final point, advance beats return point_valid=0.
// All products run through one shared multiplier with a registered accumulator under
// a small sequencer, so one beat is in flight at a time. A restart first loads the start
// value; a region 1 step compares, then updates the decision; a region 2 step only
// updates it; the step that changes region also builds the region 2 entry value, and a
// final point or a beat with no ellipse active goes straight to the result. The block
// returns to idle before the next beat is taken.
// A stalled result is held in the output register; the sequencer waits before
// loading the next one. Synchronous reset clears the configuration and the walk state
// to zero and leaves the block idle with no ellipse active.
module midpoint_ellipse_point_generator #(
  parameter int COORD_BITS = mpe_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mpe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                restart,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic                                point_valid,
  output logic signed [COORD_BITS+1:0]        x_right,
  output logic signed [COORD_BITS+1:0]        x_left,
  output logic signed [COORD_BITS+1:0]        y_lower,
  output logic signed [COORD_BITS+1:0]        y_upper,
  output logic                                final_point
);

  localparam int RB       = COORD_BITS - 1;
  localparam int SQ_BITS  = 2 * RB;
  localparam int B_BITS   = 2 * RB + 2;
  localparam int P_BITS   = SQ_BITS + B_BITS;
  localparam int DEC_BITS = 4 * COORD_BITS + 2;
  localparam int OUT_BITS = COORD_BITS + 2;

  typedef enum logic [21:0] {
    ST_IDLE = 22'h000001,
    ST_SQ_A = 22'h000002,
    ST_SQ_B = 22'h000004,
    ST_SQ_C = 22'h000008,
    ST_RS_A = 22'h000010,
    ST_RS_B = 22'h000020,
    ST_RS_C = 22'h000040,
    ST_RS_D = 22'h000080,
    ST_CM_A = 22'h000100,
    ST_CM_B = 22'h000200,
    ST_CM_C = 22'h000400,
    ST_EN_A = 22'h000800,
    ST_EN_B = 22'h001000,
    ST_EN_C = 22'h002000,
    ST_EN_D = 22'h004000,
    ST_EN_E = 22'h008000,
    ST_EN_F = 22'h010000,
    ST_UP_A = 22'h020000,
    ST_UP_B = 22'h040000,
    ST_UP_C = 22'h080000,
    ST_UP_D = 22'h100000,
    ST_DONE = 22'h200000
  } state_t;

  state_t state;
  state_t state_next;

  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [RB-1:0]         radius_x;
  logic [RB-1:0]         radius_y;
  logic [SQ_BITS-1:0]    a2;
  logic [SQ_BITS-1:0]    b2;
  logic                  sq_dirty;
  logic                  radius_wr;

  logic [RB-1:0]         offset_x;
  logic [RB-1:0]         offset_y;
  logic                  in_second_region;
  logic                  drawing_active;
  logic                  idle_res;
  logic                  xstep;
  logic                  ystep;
  logic [P_BITS-1:0]     lhs;

  logic                  accept;
  logic                  done_fire;
  logic [RB-1:0]         xn;
  logic [RB-1:0]         yn;
  logic [RB-1:0]         ty;
  logic [RB:0]           x_inc;
  logic [RB:0]           y_twice_m1;
  logic [RB:0]           tx;
  logic                  lhs_gt;
  logic                  to_second;

  mpe_pkg::mac_ctl_t     mac_ctl;
  logic [SQ_BITS-1:0]    mul_a;
  logic [B_BITS-1:0]     mul_b;
  logic [P_BITS-1:0]     prod;
  logic                  dec_neg;
  logic                  dec_zero;

  mpe_mac #(
    .A_BITS   (SQ_BITS),
    .B_BITS   (B_BITS),
    .ACC_BITS (DEC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .op_a     (mul_a),
    .op_b     (mul_b),
    .prod     (prod),
    .acc_neg  (dec_neg),
    .acc_zero (dec_zero)
  );

  assign req_stall = (state != ST_IDLE) || sq_dirty || cfg_we;
  assign accept    = req_valid && !req_stall;
  assign done_fire = (state == ST_DONE) && (!res_valid || !res_stall);
  assign radius_wr = cfg_we && (cfg_index == mpe_pkg::CFG_RADIUS_X ||
                                cfg_index == mpe_pkg::CFG_RADIUS_Y);

  assign xn         = offset_x + RB'(1);
  assign yn         = offset_y - RB'(1);
  assign x_inc      = {1'b0, offset_x} + (RB+1)'(1);
  assign y_twice_m1 = {offset_y, 1'b0} - (RB+1)'(1);
  assign tx         = {offset_x, 1'b1};
  assign ty         = (offset_y != '0) ? yn : RB'(1);

  // region 1 holds while y > 0 and a^2*(2y-1) > 2*b^2*(x+1)
  assign lhs_gt    = {1'b0, lhs} > {prod, 1'b0};
  assign to_second = (offset_y == '0) || !lhs_gt;

  always_comb begin
    state_next    = state;
    mul_a         = '0;
    mul_b         = '0;
    mac_ctl.op    = mpe_pkg::ACC_HOLD;
    mac_ctl.shift = '0;
    unique case (state)
      ST_IDLE: begin
        if (sq_dirty) begin
          state_next = ST_SQ_A;
        end else if (accept) begin
          if (restart) begin
            state_next = ST_RS_A;
          end else if (!drawing_active) begin
            state_next = ST_DONE;
          end else if (in_second_region) begin
            state_next = (offset_y == '0) ? ST_DONE : ST_UP_A;
          end else begin
            state_next = ST_CM_A;
          end
        end
      end
      ST_SQ_A: begin
        mul_a      = SQ_BITS'(radius_x);
        mul_b      = B_BITS'(radius_x);
        state_next = ST_SQ_B;
      end
      ST_SQ_B: begin
        mul_a      = SQ_BITS'(radius_y);
        mul_b      = B_BITS'(radius_y);
        state_next = ST_SQ_C;
      end
      ST_SQ_C: begin
        state_next = ST_IDLE;
      end
      // start value: 4b^2 + a^2 - 4a^2*b
      ST_RS_A: begin
        mul_a      = b2;
        mul_b      = B_BITS'(1);
        state_next = ST_RS_B;
      end
      ST_RS_B: begin
        mul_a         = a2;
        mul_b         = B_BITS'(1);
        mac_ctl.op    = mpe_pkg::ACC_LOAD;
        mac_ctl.shift = 2'd2;
        state_next    = ST_RS_C;
      end
      ST_RS_C: begin
        mul_a      = a2;
        mul_b      = B_BITS'(radius_y);
        mac_ctl.op = mpe_pkg::ACC_ADD;
        state_next = ST_RS_D;
      end
      ST_RS_D: begin
        mac_ctl.op    = mpe_pkg::ACC_SUB;
        mac_ctl.shift = 2'd2;
        state_next    = ST_CM_A;
      end
      ST_CM_A: begin
        mul_a      = a2;
        mul_b      = B_BITS'(y_twice_m1);
        state_next = ST_CM_B;
      end
      ST_CM_B: begin
        mul_a      = b2;
        mul_b      = B_BITS'(x_inc);
        state_next = ST_CM_C;
      end
      ST_CM_C: begin
        state_next = to_second ? ST_EN_A : ST_UP_A;
      end
      // region 2 entry: b^2(2x+1)^2 + 4a^2*ty^2 - 4a^2*b^2
      ST_EN_A: begin
        mul_a      = SQ_BITS'(tx);
        mul_b      = B_BITS'(tx);
        state_next = ST_EN_B;
      end
      ST_EN_B: begin
        mul_a      = b2;
        mul_b      = prod[B_BITS-1:0];
        state_next = ST_EN_C;
      end
      ST_EN_C: begin
        mul_a      = SQ_BITS'(ty);
        mul_b      = B_BITS'(ty);
        mac_ctl.op = mpe_pkg::ACC_LOAD;
        state_next = ST_EN_D;
      end
      ST_EN_D: begin
        mul_a      = a2;
        mul_b      = prod[B_BITS-1:0];
        state_next = ST_EN_E;
      end
      ST_EN_E: begin
        mul_a         = a2;
        mul_b         = B_BITS'(b2);
        mac_ctl.op    = mpe_pkg::ACC_ADD;
        mac_ctl.shift = 2'd2;
        state_next    = ST_EN_F;
      end
      ST_EN_F: begin
        mac_ctl.op    = mpe_pkg::ACC_SUB;
        mac_ctl.shift = 2'd2;
        state_next    = (offset_y == '0) ? ST_DONE : ST_UP_A;
      end
      // step: +8b^2*xn (x step), -8a^2*yn (y step), +4b^2 or +4a^2
      ST_UP_A: begin
        mul_a      = b2;
        mul_b      = B_BITS'(xn);
        state_next = ST_UP_B;
      end
      ST_UP_B: begin
        mul_a         = a2;
        mul_b         = B_BITS'(yn);
        mac_ctl.op    = xstep ? mpe_pkg::ACC_ADD : mpe_pkg::ACC_HOLD;
        mac_ctl.shift = 2'd3;
        state_next    = ST_UP_C;
      end
      ST_UP_C: begin
        mul_a         = in_second_region ? a2 : b2;
        mul_b         = B_BITS'(1);
        mac_ctl.op    = ystep ? mpe_pkg::ACC_SUB : mpe_pkg::ACC_HOLD;
        mac_ctl.shift = 2'd3;
        state_next    = ST_UP_D;
      end
      ST_UP_D: begin
        mac_ctl.op    = mpe_pkg::ACC_ADD;
        mac_ctl.shift = 2'd2;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (done_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      center_x         <= '0;
      center_y         <= '0;
      radius_x         <= '0;
      radius_y         <= '0;
      a2               <= '0;
      b2               <= '0;
      sq_dirty         <= 1'b0;
      offset_x         <= '0;
      offset_y         <= '0;
      in_second_region <= 1'b0;
      drawing_active   <= 1'b0;
      idle_res         <= 1'b0;
      xstep            <= 1'b0;
      ystep            <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (radius_wr) begin
        sq_dirty <= 1'b1;
      end else if (state == ST_IDLE && sq_dirty) begin
        sq_dirty <= 1'b0;
      end
      if (cfg_we) begin
        unique case (mpe_pkg::cfg_index_t'(cfg_index))
          mpe_pkg::CFG_CENTER_X: center_x <= cfg_data;
          mpe_pkg::CFG_CENTER_Y: center_y <= cfg_data;
          mpe_pkg::CFG_RADIUS_X: radius_x <= cfg_data[RB-1:0];
          mpe_pkg::CFG_RADIUS_Y: radius_y <= cfg_data[RB-1:0];
        endcase
      end

      if (accept) begin
        idle_res <= !restart && !drawing_active;
        xstep    <= 1'b0;
        ystep    <= 1'b0;
        if (restart) begin
          offset_x         <= '0;
          offset_y         <= radius_y;
          in_second_region <= 1'b0;
          drawing_active   <= 1'b1;
        end else if (drawing_active && in_second_region && offset_y == '0) begin
          drawing_active <= 1'b0;
        end
      end

      unique case (state)
        ST_SQ_B: a2 <= prod[SQ_BITS-1:0];
        ST_SQ_C: b2 <= prod[SQ_BITS-1:0];
        ST_CM_C: begin
          if (to_second) begin
            in_second_region <= 1'b1;
          end
        end
        ST_EN_F: begin
          if (offset_y == '0) begin
            drawing_active <= 1'b0;
          end
        end
        ST_UP_A: begin
          // the decision here is the one before this step's update
          if (in_second_region) begin
            xstep <= dec_neg || dec_zero;
            ystep <= 1'b1;
          end else begin
            xstep <= 1'b1;
            ystep <= !dec_neg;
          end
        end
        ST_DONE: begin
          if (done_fire) begin
            if (xstep) begin
              offset_x <= xn;
            end
            if (ystep) begin
              offset_y <= yn;
            end
          end
        end
        default: begin
        end
      endcase

      if (done_fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CM_B) begin
      lhs <= prod;
    end
    if (done_fire) begin
      if (idle_res) begin
        point_valid <= 1'b0;
        x_right     <= '0;
        x_left      <= '0;
        y_lower     <= '0;
        y_upper     <= '0;
        final_point <= 1'b0;
      end else begin
        point_valid <= 1'b1;
        x_right     <= OUT_BITS'(center_x) + OUT_BITS'(offset_x);
        x_left      <= OUT_BITS'(center_x) - OUT_BITS'(offset_x);
        y_lower     <= OUT_BITS'(center_y) + OUT_BITS'(offset_y);
        y_upper     <= OUT_BITS'(center_y) - OUT_BITS'(offset_y);
        final_point <= in_second_region && (offset_y == '0);
      end
    end
  end

  // a radius write must hold off requests until the squares are rebuilt
  a_radius_write_stalls: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == mpe_pkg::CFG_RADIUS_X || cfg_index == mpe_pkg::CFG_RADIUS_Y))
    |=> req_stall)
    else $error("request not stalled after radius write");

  a_final_is_point: assert property (@(posedge clk) disable iff (rst)
    (res_valid && final_point) |-> point_valid)
    else $error("final flag on an empty result");

  a_final_ends_drawing: assert property (@(posedge clk) disable iff (rst)
    (done_fire && !idle_res && in_second_region && offset_y == '0) |=> !drawing_active)
    else $error("ellipse still active after final point");

  a_region2_steps_y: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_B && in_second_region) |-> ystep)
    else $error("region 2 step without y decrement");

  a_region1_steps_x: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_B && !in_second_region) |-> xstep)
    else $error("region 1 step without x increment");

endmodule

/* tb/sv/midpoint_ellipse_point_generator_test.sv */
module midpoint_ellipse_point_generator_test;

  localparam int CB = mpe_pkg::COORD_BITS_DEF;
  localparam int OW = CB + 2;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic          pv;
    logic [OW-1:0] xr;
    logic [OW-1:0] xl;
    logic [OW-1:0] yl;
    logic [OW-1:0] yu;
    logic          fin;
  } point_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [mpe_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CB-1:0]                    cfg_data = '0;
  logic                             req_valid = 1'b0;
  logic                             req_stall;
  logic                             restart = 1'b0;
  logic                             res_valid;
  logic                             res_stall = 1'b0;
  logic                             point_valid;
  logic signed [OW-1:0]             x_right;
  logic signed [OW-1:0]             x_left;
  logic signed [OW-1:0]             y_lower;
  logic signed [OW-1:0]             y_upper;
  logic                             final_point;

  midpoint_ellipse_point_generator #(.COORD_BITS(CB)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .restart     (restart),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .point_valid (point_valid),
    .x_right     (x_right),
    .x_left      (x_left),
    .y_lower     (y_lower),
    .y_upper     (y_upper),
    .final_point (final_point)
  );

  always #4 clk = ~clk;

  // ellipse walker state, mirrors the block
  logic [CB-1:0]   ctr_x = '0;
  logic [CB-1:0]   ctr_y = '0;
  logic [CB-2:0]   rad_x = '0;
  logic [CB-2:0]   rad_y = '0;
  logic [CB-2:0]   off_x = '0;
  logic [CB-2:0]   off_y = '0;
  logic [63:0]     mid_dec = '0;
  logic            in_region2 = 1'b0;
  logic            drawing = 1'b0;

  point_t pending_points[$];
  int     errors = 0;
  int     beats_sent = 0;
  int     cycles = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_asked = 0;
  int     hold_taken = 0;
  int     hold_left = 0;

  function automatic point_t plot_next_point(logic rs);
    logic [63:0] a2, b2, x, y, tx, ty, s;
    longint      lhs, rhs;
    logic        neg;
    point_t      p;
    a2 = 64'(rad_x) * 64'(rad_x);
    b2 = 64'(rad_y) * 64'(rad_y);
    p = '0;
    if (rs) begin
      off_x = '0;
      off_y = rad_y;
      mid_dec = 64'd4 * b2 - 64'd4 * a2 * 64'(rad_y) + a2;
      in_region2 = 1'b0;
      drawing = 1'b1;
    end
    if (!drawing) return p;
    x = 64'(off_x);
    y = 64'(off_y);
    if (!in_region2) begin
      lhs = longint'(a2) * (2 * longint'(y) - 1);
      rhs = longint'(64'd2 * b2 * (x + 64'd1));
      if (!(lhs > rhs)) begin
        tx = 64'd2 * x + 64'd1;
        ty = (y > 0) ? (y - 64'd1) : 64'd1;
        in_region2 = 1'b1;
        mid_dec = b2 * tx * tx + 64'd4 * a2 * ty * ty - 64'd4 * a2 * b2;
      end
    end
    p.pv = 1'b1;
    s = 64'(ctr_x) + x;  p.xr = s[OW-1:0];
    s = 64'(ctr_x) - x;  p.xl = s[OW-1:0];
    s = 64'(ctr_y) + y;  p.yl = s[OW-1:0];
    s = 64'(ctr_y) - y;  p.yu = s[OW-1:0];
    p.fin = in_region2 && (y == 0);
    if (!in_region2) begin
      neg = mid_dec[63];
      x = x + 64'd1;
      x = 64'(x[CB-2:0]);
      if (!neg) begin
        y = y - 64'd1;
        y = 64'(y[CB-2:0]);
        mid_dec = mid_dec - 64'd8 * a2 * y;
      end
      mid_dec = mid_dec + 64'd8 * b2 * x + 64'd4 * b2;
    end else if (y == 0) begin
      drawing = 1'b0;
    end else if (!mid_dec[63] && mid_dec != 0) begin
      y = y - 64'd1;
      mid_dec = mid_dec + 64'd4 * a2 - 64'd8 * a2 * y;
    end else begin
      x = x + 64'd1;
      x = 64'(x[CB-2:0]);
      y = y - 64'd1;
      mid_dec = mid_dec + 64'd8 * b2 * x - 64'd8 * a2 * y + 64'd4 * a2;
    end
    off_x = x[CB-2:0];
    off_y = y[CB-2:0];
    return p;
  endfunction

  function void check_field(string fname, logic signed [15:0] want, logic signed [15:0] got);
    if (got !== want) begin
      if (errors < 30)
        $display("%0t %s: expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endfunction

  // result side: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_points.size() == 0) begin
        if (errors < 30) $display("%0t result beat with nothing expected", $time);
        errors++;
      end else begin
        want = pending_points.pop_front();
        check_field("point_valid", want.pv, point_valid);
        check_field("x_right", $signed(want.xr), x_right);
        check_field("x_left", $signed(want.xl), x_left);
        check_field("y_lower", $signed(want.yl), y_lower);
        check_field("y_upper", $signed(want.yu), y_upper);
        check_field("final_point", want.fin, final_point);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_points.push_back(plot_next_point(rs));
    beats_sent++;
  endtask

  task automatic quiesce();
    req_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(mpe_pkg::cfg_index_t idx, logic [CB-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      mpe_pkg::CFG_CENTER_X: ctr_x = val;
      mpe_pkg::CFG_CENTER_Y: ctr_y = val;
      mpe_pkg::CFG_RADIUS_X: rad_x = val[CB-2:0];
      mpe_pkg::CFG_RADIUS_Y: rad_y = val[CB-2:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ellipse(logic [CB-1:0] cx, logic [CB-1:0] cy,
                             logic [CB-1:0] rx, logic [CB-1:0] ry);
    quiesce();
    write_reg(mpe_pkg::CFG_CENTER_X, cx);
    write_reg(mpe_pkg::CFG_CENTER_Y, cy);
    write_reg(mpe_pkg::CFG_RADIUS_X, rx);
    write_reg(mpe_pkg::CFG_RADIUS_Y, ry);
  endtask

  // the top radius bit is beyond the register and must be dropped
  function automatic logic [CB-1:0] pick_radius();
    logic [CB-1:0] r;
    int            roll;
    roll = $urandom_range(99);
    if (roll < 3)       r = CB'((1 << (CB - 1)) - 1);
    else if (roll < 6)  r = CB'($urandom_range((1 << (CB - 1)) - 1));
    else if (roll < 11) r = '0;
    else                r = CB'($urandom_range(1, 30));
    r[CB-1] = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic logic [CB-1:0] pick_center();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CB'($urandom_range((1 << CB) - 1));
  endfunction

  task automatic trace_ellipse(int cap, bit resume);
    int n;
    n = 0;
    if (!resume) send_beat(1'b1);
    while (drawing && n < cap) begin
      if ($urandom_range(99) < 3) send_beat(1'b1);  // drop the walk and start over
      else send_beat(1'b0);
      n++;
    end
  endtask

  task automatic test_idle_after_reset();
    send_beat(1'b0);
    send_beat(1'b0);
  endtask

  task automatic test_zero_radii();
    set_ellipse(12'd100, 12'd200, 12'd5, 12'd0);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    set_ellipse(12'd7, 12'd9, 12'd0, 12'd3);
    send_beat(1'b1);
    repeat (4) send_beat(1'b0);
  endtask

  task automatic test_extremes();
    set_ellipse('1, '0, '1, '1);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b0);
    // registers change under a walk in progress
    quiesce();
    write_reg(mpe_pkg::CFG_CENTER_X, '0);
    write_reg(mpe_pkg::CFG_CENTER_Y, '1);
    write_reg(mpe_pkg::CFG_RADIUS_X, 12'd3);
    repeat (3) send_beat(1'b0);
  endtask

  task automatic test_small_walk();
    set_ellipse(12'd50, 12'd50, 12'd2, 12'd1);
    trace_ellipse(10, 1'b0);
  endtask

  task automatic test_random_walks(int target);
    while (beats_sent < target) begin
      set_ellipse(pick_center(), pick_center(), pick_radius(), pick_radius());
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(9) == 0) send_beat(1'b0);
        if ($urandom_range(9) == 0) begin
          send_beat(1'b1);
          repeat (3) send_beat(1'b0);
          quiesce();
          write_reg(mpe_pkg::CFG_CENTER_X, pick_center());
          write_reg(mpe_pkg::CFG_CENTER_Y, pick_center());
          trace_ellipse(150, 1'b1);
        end else begin
          trace_ellipse(150, 1'b0);
        end
        repeat ($urandom_range(0, 2)) send_beat(1'b0);
      end
    end
  endtask

  task automatic test_result_hold();
    set_ellipse(12'd300, 12'd300, 12'd20, 12'd12);
    hold_asked++;
    send_beat(1'b1);
    repeat (15) send_beat(1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 62;
    test_idle_after_reset();
    test_zero_radii();
    test_extremes();
    test_small_walk();
    test_random_walks(500);
    send_idle_pct = 62;
    recv_idle_pct = 11;
    test_random_walks(975);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_result_hold();
    test_random_walks(1450);
    quiesce();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* midpoint_ellipse_point_generator.f */
hw/rtl/mpe_pkg.sv
hw/rtl/mpe_mac.sv
hw/rtl/midpoint_ellipse_point_generator.sv
tb/sv/midpoint_ellipse_point_generator_test.sv
